FILE: design/patch_list_stream_validator_defines.svh
// ----------------------------------------------------------------------------
// Patch-list stream validator assertion macros
// Shared property forms for the validator checks.
// ----------------------------------------------------------------------------
`ifndef PATCH_LIST_STREAM_VALIDATOR_DEFINES_SVH
`define PATCH_LIST_STREAM_VALIDATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PLSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PLSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/plsv_pkg.sv
// ----------------------------------------------------------------------------
// plsv_pkg
// Types and constants shared by the patch-list stream validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plsv_pkg;

  localparam logic [63:0] HDR_LEN       = 64'd24;
  localparam logic [63:0] HDR_LAST_POS  = 64'd23;
  // largest item count whose required length still fits in 64 bits
  localparam logic [63:0] MAX_ITEMS     = 64'h3333_3333_3333_332E;

  localparam logic        REG_MAGIC     = 1'b0;
  localparam logic        REG_VERSION   = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT_HEADER = 3'd1,
    ST_BAD_MAGIC    = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_SHORT_BODY   = 3'd4,
    ST_INDEX_RANGE  = 3'd5,
    ST_INDEX_ORDER  = 3'd6
  } plsv_status_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_RANGE = 2'd1,
    FAULT_ORDER = 2'd2
  } plsv_fault_t;

  typedef struct packed {
    logic         valid;
    plsv_status_t status;
    logic [63:0]  target_bytes;
    logic [63:0]  item_total;
  } plsv_result_t;

endpackage

FILE: design/plsv_cfg_regs.sv
// ----------------------------------------------------------------------------
// plsv_cfg_regs
// APB register file holding the expected magic word and format version.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plsv_cfg_regs
  import plsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] expected_magic,
  output logic [31:0] expected_version
);

  logic [31:0] magic_r;
  logic [31:0] magic_nxt;
  logic [31:0] version_r;
  logic [31:0] version_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    magic_nxt   = magic_r;
    version_nxt = version_r;
    prdata      = 32'd0;
    unique case (paddr[2])
      REG_MAGIC: begin
        prdata = magic_r;
        if (wr_en) magic_nxt = pwdata;
      end
      REG_VERSION: begin
        prdata = version_r;
        if (wr_en) version_nxt = pwdata;
      end
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= 32'd0;
      version_r <= 32'd0;
    end else begin
      magic_r   <= magic_nxt;
      version_r <= version_nxt;
    end
  end

  assign expected_magic   = magic_r;
  assign expected_version = version_r;

endmodule

FILE: design/plsv_stream_core.sv
// ----------------------------------------------------------------------------
// plsv_stream_core
// Per-byte header assembly, index checking and final status selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plsv_stream_core
  import plsv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  input  logic [31:0]  expected_magic,
  input  logic [31:0]  expected_version,
  output plsv_result_t res
);

  logic [63:0] seen_r,      seen_nxt;
  logic [31:0] magic_r,     magic_nxt;
  logic [31:0] version_r,   version_nxt;
  logic [63:0] target_r,    target_nxt;
  logic [63:0] count_r,     count_nxt;
  logic [31:0] asm_r,       asm_nxt;
  logic [31:0] prev_r,      prev_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic [63:0] remain_r,    remain_nxt;
  logic [63:0] need_m1_r,   need_m1_nxt;
  logic        too_big_r,   too_big_nxt;
  plsv_fault_t fault_r,     fault_nxt;

  logic        sat;
  logic        take;
  logic        hdr_phase;
  logic        hdr_end;
  logic [4:0]  pos;
  logic [1:0]  lane;
  logic [65:0] need_wide;
  logic [31:0] idx_word;
  logic        range_bad;
  logic        order_bad;
  logic        short_hdr;
  logic        short_body;
  plsv_status_t status;

  assign sat       = &seen_r;
  assign take      = accept && !sat;
  assign hdr_phase = seen_r < HDR_LEN;
  assign hdr_end   = seen_r == HDR_LAST_POS;
  assign pos       = seen_r[4:0];
  assign lane      = seen_r[1:0];

  // header field assembly
  always_comb begin
    magic_nxt   = magic_r;
    version_nxt = version_r;
    target_nxt  = target_r;
    count_nxt   = count_r;
    if (take && hdr_phase) begin
      priority if (pos[4:3] == 2'b00 && !pos[2]) begin
        magic_nxt[{pos[1:0], 3'b000} +: 8] = data_byte;
      end else if (pos[4:3] == 2'b00) begin
        version_nxt[{pos[1:0], 3'b000} +: 8] = data_byte;
      end else if (pos[4:3] == 2'b01) begin
        target_nxt[{pos[2:0], 3'b000} +: 8] = data_byte;
      end else begin
        count_nxt[{pos[2:0], 3'b000} +: 8] = data_byte;
      end
    end
  end

  // required length minus one: 23 + 5 * count
  assign need_wide = {count_nxt, 2'b00} + {2'b00, count_nxt} + 66'd23;

  assign idx_word  = {data_byte, asm_r[23:0]};
  assign range_bad = (target_r[63:32] == 32'd0) && (idx_word >= target_r[31:0]);
  assign order_bad = have_prev_r && (idx_word <= prev_r);

  always_comb begin
    seen_nxt      = seen_r;
    asm_nxt       = asm_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    remain_nxt    = remain_r;
    need_m1_nxt   = need_m1_r;
    too_big_nxt   = too_big_r;
    fault_nxt     = fault_r;

    if (take) begin
      seen_nxt = seen_r + 64'd1;
      if (hdr_phase) begin
        if (hdr_end) begin
          remain_nxt    = count_nxt;
          have_prev_nxt = 1'b0;
          need_m1_nxt   = need_wide[63:0];
          too_big_nxt   = count_nxt > MAX_ITEMS;
        end
      end else if (remain_r != 64'd0) begin
        asm_nxt[{lane, 3'b000} +: 8] = data_byte;
        if (lane == 2'b11) begin
          if (fault_r == FAULT_NONE) begin
            priority if (range_bad) fault_nxt = FAULT_RANGE;
            else if (order_bad) fault_nxt = FAULT_ORDER;
          end
          prev_nxt      = idx_word;
          have_prev_nxt = 1'b1;
          remain_nxt    = remain_r - 64'd1;
        end
      end
    end

    // buffer length after this byte, compared through the pre-decremented bound
    short_hdr  = !sat && (seen_r < HDR_LAST_POS);
    short_body = hdr_end ? (count_nxt != 64'd0)
                         : (too_big_r || (!sat && (seen_r < need_m1_r)));

    priority if (short_hdr)                       status = ST_SHORT_HEADER;
    else if (magic_r != expected_magic)           status = ST_BAD_MAGIC;
    else if (version_r != expected_version)       status = ST_BAD_VERSION;
    else if (short_body)                          status = ST_SHORT_BODY;
    else if (fault_nxt == FAULT_RANGE)            status = ST_INDEX_RANGE;
    else if (fault_nxt == FAULT_ORDER)            status = ST_INDEX_ORDER;
    else                                          status = ST_OK;

    res.valid        = accept && last_byte;
    res.status       = status;
    res.target_bytes = short_hdr ? 64'd0 : target_nxt;
    res.item_total   = short_hdr ? 64'd0 : count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      seen_r      <= 64'd0;
      magic_r     <= 32'd0;
      version_r   <= 32'd0;
      target_r    <= 64'd0;
      count_r     <= 64'd0;
      asm_r       <= 32'd0;
      prev_r      <= 32'd0;
      have_prev_r <= 1'b0;
      remain_r    <= 64'd0;
      need_m1_r   <= 64'd0;
      too_big_r   <= 1'b0;
      fault_r     <= FAULT_NONE;
    end else begin
      seen_r      <= seen_nxt;
      magic_r     <= magic_nxt;
      version_r   <= version_nxt;
      target_r    <= target_nxt;
      count_r     <= count_nxt;
      asm_r       <= asm_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      remain_r    <= remain_nxt;
      need_m1_r   <= need_m1_nxt;
      too_big_r   <= too_big_nxt;
      fault_r     <= fault_nxt;
    end
  end

endmodule

FILE: design/plsv_result_stage.sv
// ----------------------------------------------------------------------------
// plsv_result_stage
// Output register for the status transaction; frees the input side when empty
// or draining.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plsv_result_stage
  import plsv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  plsv_result_t res,
  input  logic         out_ready,
  output logic         slot_free,
  output logic         out_valid,
  output logic [2:0]   out_status,
  output logic [63:0]  out_target_bytes,
  output logic [63:0]  out_item_total
);

  logic         valid_r;
  logic         valid_nxt;
  plsv_status_t status_r;
  logic [63:0]  target_r;
  logic [63:0]  items_r;

  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // hold payload until a new transaction lands
  always_ff @(posedge clk) begin
    if (res.valid) begin
      status_r <= res.status;
      target_r <= res.target_bytes;
      items_r  <= res.item_total;
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_target_bytes = target_r;
  assign out_item_total   = items_r;

endmodule

FILE: design/patch_list_stream_validator.sv
// ----------------------------------------------------------------------------
// patch_list_stream_validator
// Byte-stream checker for patch-list buffers: header, index range and order.
//
//   channel  | ports                                   | moves
//   ---------+-----------------------------------------+-----------------------
//   in       | in_valid/in_ready, in_data_byte, last   | one buffer byte
//   out      | out_valid/out_ready, status, counts     | one status per buffer
//   cfg      | psel/penable/pwrite/paddr/pwdata/prdata | magic, version regs
//
// One byte per clock while in_ready is high; bytes decode in the cycle taken.
// The registered status appears in the cycle after the last byte is taken.
// in_ready drops only while a status waits with out_ready low.
// Synchronous active-low reset clears all stream state and both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module patch_list_stream_validator
  import plsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [63:0] out_target_bytes,
  output logic [63:0] out_item_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "patch_list_stream_validator_defines.svh"

  logic         accept;
  logic [31:0]  expected_magic;
  logic [31:0]  expected_version;
  plsv_result_t res;

  assign accept = in_valid && in_ready;

  plsv_cfg_regs u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .expected_magic   (expected_magic),
    .expected_version (expected_version)
  );

  plsv_stream_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .data_byte        (in_data_byte),
    .last_byte        (in_last_byte),
    .expected_magic   (expected_magic),
    .expected_version (expected_version),
    .res              (res)
  );

  plsv_result_stage u_result (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .out_ready        (out_ready),
    .slot_free        (in_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_target_bytes (out_target_bytes),
    .out_item_total   (out_item_total)
  );

  `PLSV_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while status stalled")
  `PLSV_ASSERT_NXT(a_last_gives_status, clk, rst_n, in_valid && in_ready && in_last_byte, out_valid, "no status after last byte")
  `PLSV_ASSERT_IMP(a_short_hdr_zero, clk, rst_n, out_valid && (out_status == ST_SHORT_HEADER), (out_target_bytes == 64'd0) && (out_item_total == 64'd0), "short header status with nonzero counts")

endmodule
